// File: rtl/core/wavp_pkg.sv
package wavp_pkg;

	// Chunk tags as they read after four bytes go through a little-endian shift line
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_LIST = 32'h5453_494c;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_SKIP    = 3'd2;
	localparam logic [2:0] KIND_ERROR   = 3'd3;
	localparam logic [2:0] KIND_EXTRA   = 3'd4;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_NO_RIFF = 3'd1;
	localparam logic [2:0] ERR_NO_WAVE = 3'd2;
	localparam logic [2:0] ERR_NO_FMT  = 3'd3;
	localparam logic [2:0] ERR_NO_DATA = 3'd4;

	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	typedef struct packed {
		logic [7:0] file_byte;
		logic       restart;
	} wavp_in_t;

	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [2:0]  error_code;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic        header_valid;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		logic [31:0] data_length;
	} wavp_out_t;

	// Classified word handed from the front to the parser
	typedef struct packed {
		logic [7:0]  file_byte;
		logic        restart;
		logic [31:0] shift;
		logic        shift_zero;
		logic        is_riff;
		logic        is_wave;
		logic        is_fmt;
		logic        is_list;
		logic        is_data;
	} wavp_item_t;

endpackage

// File: rtl/core/wavp_front.sv
module wavp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 file_valid,
	output logic                 file_stall,
	input  wavp_pkg::wavp_in_t   file_word,
	output logic                 push_valid,
	input  logic                 push_full,
	output wavp_pkg::wavp_item_t push_item
);

	logic                 valid_s1;
	wavp_pkg::wavp_item_t item_s1;
	logic [31:0]          shift_q;
	logic [31:0]          shift_next;
	logic                 accept;

	assign file_stall = valid_s1 && push_full;
	assign accept     = file_valid && !file_stall;

	// restart clears the history before the new byte shifts in
	assign shift_next = file_word.restart ? {file_word.file_byte, 24'd0}
	                                      : {file_word.file_byte, shift_q[31:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				shift_q  <= shift_next;
				valid_s1 <= 1'b1;
			end else if (!push_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.file_byte  <= file_word.file_byte;
			item_s1.restart    <= file_word.restart;
			item_s1.shift      <= shift_next;
			item_s1.shift_zero <= (shift_next == 32'd0);
			item_s1.is_riff    <= (shift_next == wavp_pkg::TAG_RIFF);
			item_s1.is_wave    <= (shift_next == wavp_pkg::TAG_WAVE);
			item_s1.is_fmt     <= (shift_next == wavp_pkg::TAG_FMT);
			item_s1.is_list    <= (shift_next == wavp_pkg::TAG_LIST);
			item_s1.is_data    <= (shift_next == wavp_pkg::TAG_DATA);
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// File: rtl/core/wavp_queue.sv
module wavp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_full,
	input  wavp_pkg::wavp_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output wavp_pkg::wavp_item_t pop_item
);

	wavp_pkg::wavp_item_t              entry_q [wavp_pkg::QueueDepth];
	logic [wavp_pkg::QueuePtrW-1:0]    wr_ptr_q;
	logic [wavp_pkg::QueuePtrW-1:0]    rd_ptr_q;
	logic [wavp_pkg::QueueCntW-1:0]    count_q;
	logic                              push;
	logic                              pop;

	assign push_full = (count_q == wavp_pkg::QueueCntW'(wavp_pkg::QueueDepth));
	assign pop_valid = (count_q != '0);
	assign push      = push_valid && !push_full;
	assign pop       = pop_valid && pop_ready;
	assign pop_item  = entry_q[rd_ptr_q];

	function automatic logic [wavp_pkg::QueuePtrW-1:0] next_ptr(
		input logic [wavp_pkg::QueuePtrW-1:0] ptr
	);
		if (ptr == wavp_pkg::QueuePtrW'(wavp_pkg::QueueDepth - 1))
			return '0;
		return ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/core/wavp_back.sv
module wavp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  wavp_pkg::wavp_item_t pop_item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output wavp_pkg::wavp_out_t  result_word
);

	typedef enum logic [12:0] {
		PH_RIFF    = 13'b0_0000_0000_0001,
		PH_RSIZE   = 13'b0_0000_0000_0010,
		PH_WAVE    = 13'b0_0000_0000_0100,
		PH_FMTTAG  = 13'b0_0000_0000_1000,
		PH_FMTBODY = 13'b0_0000_0001_0000,
		PH_CHUNK   = 13'b0_0000_0010_0000,
		PH_LSIZE   = 13'b0_0000_0100_0000,
		PH_SKIP    = 13'b0_0000_1000_0000,
		PH_DATATAG = 13'b0_0001_0000_0000,
		PH_DSIZE   = 13'b0_0010_0000_0000,
		PH_PAY     = 13'b0_0100_0000_0000,
		PH_DONE    = 13'b0_1000_0000_0000,
		PH_ERR     = 13'b1_0000_0000_0000
	} phase_t;

	phase_t      phase_q, e_phase, n_phase;
	logic [4:0]  pos_q, e_pos, n_pos;
	logic [31:0] skip_q, e_skip, n_skip;
	logic [31:0] rem_q, e_rem, n_rem;
	logic [15:0] chan_q, e_chan, n_chan;
	logic [31:0] rate_q, e_rate, n_rate;
	logic [15:0] bits_q, e_bits, n_bits;
	logic [31:0] len_q, e_len, n_len;
	logic [2:0]  err_q, e_err, n_err;
	logic [2:0]  kind;
	logic [7:0]  pay;
	logic        last;
	logic        valid_q;
	logic        pop;
	logic [7:0]  b;

	assign pop_ready = !valid_q || !result_stall;
	assign pop       = pop_valid && pop_ready;
	assign b         = pop_item.file_byte;

	always_comb begin
		// restart: take this byte as the first one of a fresh file
		if (pop_item.restart) begin
			e_phase = PH_RIFF;
			e_pos   = '0;
			e_skip  = '0;
			e_rem   = '0;
			e_chan  = '0;
			e_rate  = '0;
			e_bits  = '0;
			e_len   = '0;
			e_err   = wavp_pkg::ERR_NONE;
		end else begin
			e_phase = phase_q;
			e_pos   = pos_q;
			e_skip  = skip_q;
			e_rem   = rem_q;
			e_chan  = chan_q;
			e_rate  = rate_q;
			e_bits  = bits_q;
			e_len   = len_q;
			e_err   = err_q;
		end

		n_phase = e_phase;
		n_pos   = e_pos;
		n_skip  = e_skip;
		n_rem   = e_rem;
		n_chan  = e_chan;
		n_rate  = e_rate;
		n_bits  = e_bits;
		n_len   = e_len;
		n_err   = e_err;
		kind    = wavp_pkg::KIND_HEADER;
		pay     = 8'd0;
		last    = 1'b0;

		case (e_phase)
			PH_RIFF, PH_WAVE, PH_FMTTAG, PH_CHUNK, PH_DATATAG: begin
				if (e_pos < 5'd3) begin
					n_pos = e_pos + 5'd1;
				end else begin
					n_pos = '0;
					case (e_phase)
						PH_RIFF: begin
							if (pop_item.is_riff) begin
								n_phase = PH_RSIZE;
							end else begin
								n_phase = PH_ERR;
								n_err   = wavp_pkg::ERR_NO_RIFF;
							end
						end
						PH_WAVE: begin
							if (pop_item.is_wave) begin
								n_phase = PH_FMTTAG;
							end else begin
								n_phase = PH_ERR;
								n_err   = wavp_pkg::ERR_NO_WAVE;
							end
						end
						PH_FMTTAG: begin
							if (pop_item.is_fmt) begin
								n_phase = PH_FMTBODY;
							end else begin
								n_phase = PH_ERR;
								n_err   = wavp_pkg::ERR_NO_FMT;
							end
						end
						PH_CHUNK: begin
							if (pop_item.is_list) begin
								n_phase = PH_LSIZE;
							end else if (pop_item.is_data) begin
								n_phase = PH_DSIZE;
							end else begin
								n_phase = PH_ERR;
								n_err   = wavp_pkg::ERR_NO_DATA;
							end
						end
						default: begin
							// a second LIST lands here as a missing data tag
							if (pop_item.is_data) begin
								n_phase = PH_DSIZE;
							end else begin
								n_phase = PH_ERR;
								n_err   = wavp_pkg::ERR_NO_DATA;
							end
						end
					endcase
					if (n_phase == PH_ERR)
						kind = wavp_pkg::KIND_ERROR;
				end
			end
			PH_RSIZE: begin
				if (e_pos < 5'd3) begin
					n_pos = e_pos + 5'd1;
				end else begin
					n_pos   = '0;
					n_phase = PH_WAVE;
				end
			end
			PH_FMTBODY: begin
				case (e_pos)
					5'd6:    n_chan[7:0]   = e_chan[7:0] | b;
					5'd7:    n_chan[15:8]  = e_chan[15:8] | b;
					5'd8:    n_rate[7:0]   = e_rate[7:0] | b;
					5'd9:    n_rate[15:8]  = e_rate[15:8] | b;
					5'd10:   n_rate[23:16] = e_rate[23:16] | b;
					5'd11:   n_rate[31:24] = e_rate[31:24] | b;
					5'd18:   n_bits[7:0]   = e_bits[7:0] | b;
					5'd19:   n_bits[15:8]  = e_bits[15:8] | b;
					default: ;
				endcase
				if (e_pos >= 5'd19) begin
					n_pos   = '0;
					n_phase = PH_CHUNK;
				end else begin
					n_pos = e_pos + 5'd1;
				end
			end
			PH_LSIZE: begin
				if (e_pos < 5'd3) begin
					n_pos = e_pos + 5'd1;
				end else begin
					// the shift line now holds the whole size word
					n_pos   = '0;
					n_skip  = pop_item.shift;
					n_phase = pop_item.shift_zero ? PH_DATATAG : PH_SKIP;
				end
			end
			PH_SKIP: begin
				kind   = wavp_pkg::KIND_SKIP;
				n_skip = e_skip - 32'd1;
				if (e_skip == 32'd1)
					n_phase = PH_DATATAG;
			end
			PH_DSIZE: begin
				case (e_pos[1:0])
					2'd0:    n_len[7:0]   = e_len[7:0] | b;
					2'd1:    n_len[15:8]  = e_len[15:8] | b;
					2'd2:    n_len[23:16] = e_len[23:16] | b;
					default: n_len[31:24] = e_len[31:24] | b;
				endcase
				if (e_pos < 5'd3) begin
					n_pos = e_pos + 5'd1;
				end else begin
					n_pos   = '0;
					n_rem   = n_len;
					n_phase = pop_item.shift_zero ? PH_DONE : PH_PAY;
				end
			end
			PH_PAY: begin
				kind  = wavp_pkg::KIND_PAYLOAD;
				pay   = b;
				n_rem = e_rem - 32'd1;
				if (e_rem == 32'd1) begin
					last    = 1'b1;
					n_phase = PH_DONE;
				end
			end
			PH_DONE: kind = wavp_pkg::KIND_EXTRA;
			default: kind = wavp_pkg::KIND_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			pos_q   <= '0;
			skip_q  <= '0;
			rem_q   <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			len_q   <= '0;
			err_q   <= wavp_pkg::ERR_NONE;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= n_phase;
				pos_q   <= n_pos;
				skip_q  <= n_skip;
				rem_q   <= n_rem;
				chan_q  <= n_chan;
				rate_q  <= n_rate;
				bits_q  <= n_bits;
				len_q   <= n_len;
				err_q   <= n_err;
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_word.byte_kind     <= kind;
			result_word.error_code    <= n_err;
			result_word.payload_byte  <= pay;
			result_word.payload_last  <= last;
			result_word.header_valid  <= (n_phase == PH_PAY) || (n_phase == PH_DONE);
			result_word.channel_count <= n_chan;
			result_word.sample_rate   <= n_rate;
			result_word.sample_bits   <= n_bits;
			result_word.data_length   <= n_len;
		end
	end

	assign result_valid = valid_q;

endmodule

// File: rtl/core/wav_header_parser_unit.sv
// RIFF/WAVE header parser. Feed the file one byte per word on file_*; each byte gives exactly
// one result word on result_*, in order. Unless result_stall holds it, the block sustains one
// byte per clock: the front stage keeps the last four bytes and matches them against the
// chunk tags, a two-word queue decouples it from the parser state machine in the back stage,
// which retires one byte per cycle into the output register. An unstalled byte's result is
// registered in the front stage, the queue and the back stage. Set restart on the first byte
// of every new file; it clears all parser state, including a latched tag error. The fmt chunk
// is taken as the fixed 16-byte PCM layout, at most one LIST chunk is skipped, and the data
// chunk's bytes pass through with the last one marked; later bytes are reported as extra.
module wav_header_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                file_valid,
	output logic                file_stall,
	input  wavp_pkg::wavp_in_t  file_word,
	output logic                result_valid,
	input  logic                result_stall,
	output wavp_pkg::wavp_out_t result_word
);

	logic                 push_valid;
	logic                 push_full;
	wavp_pkg::wavp_item_t push_item;
	logic                 pop_valid;
	logic                 pop_ready;
	wavp_pkg::wavp_item_t pop_item;

	wavp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.file_stall (file_stall),
		.file_word  (file_word),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_item  (push_item)
	);

	wavp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	wavp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule

// File: rtl/core/wavp_checker.sv
module wavp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input wavp_pkg::wavp_out_t result_word
);

	// hold a stalled result word
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_word))
		else $error("result_word changed while stalled");

	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.payload_last |->
			result_word.byte_kind == wavp_pkg::KIND_PAYLOAD)
		else $error("payload_last on a non-payload byte");

	a_payload_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.byte_kind == wavp_pkg::KIND_PAYLOAD |->
			result_word.header_valid && result_word.error_code == wavp_pkg::ERR_NONE)
		else $error("payload byte without a valid header");

	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.byte_kind == wavp_pkg::KIND_ERROR |->
			result_word.error_code != wavp_pkg::ERR_NONE)
		else $error("error byte without an error code");

endmodule

bind wav_header_parser_unit wavp_checker u_wavp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_word  (result_word)
);

// File: sim/wav_header_parser_unit_test.sv
`timescale 1ns / 1ps

module wav_header_parser_unit_test;

	typedef enum logic [3:0] {
		P_RIFF, P_RSIZE, P_WAVE, P_FMTTAG, P_FMTBODY, P_CHUNK, P_LSIZE,
		P_SKIP, P_DATATAG, P_DSIZE, P_PAY, P_DONE, P_ERROR
	} parse_phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                file_valid = 1'b0;
	logic                file_stall;
	wavp_pkg::wavp_in_t  file_word = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	wavp_pkg::wavp_out_t result_word;

	// stimulus and expectations
	wavp_pkg::wavp_in_t  file_bytes[$];
	wavp_pkg::wavp_out_t predicted_words[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int files_built = 0;
	int input_stalls = 0;
	int kind_count[5];
	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int recv_calm = 0;
	int choke_left = 0;
	bit choke_done = 1'b0;

	// parser state as the predictor sees it
	parse_phase_t phase;
	logic [5:0]   pos;
	logic [31:0]  shift_line;
	logic [31:0]  skip_left;
	logic [31:0]  pay_left;
	logic [15:0]  chans;
	logic [31:0]  rate;
	logic [15:0]  bits;
	logic [31:0]  length;
	logic [2:0]   err;

	wav_header_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.file_valid   (file_valid),
		.file_stall   (file_stall),
		.file_word    (file_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_parse();
		phase = P_RIFF;
		pos = '0;
		shift_line = '0;
		skip_left = '0;
		pay_left = '0;
		chans = '0;
		rate = '0;
		bits = '0;
		length = '0;
		err = wavp_pkg::ERR_NONE;
	endfunction

	function automatic void enter_error(logic [2:0] code);
		err = code;
		phase = P_ERROR;
		pos = '0;
	endfunction

	function automatic wavp_pkg::wavp_out_t parse_byte(wavp_pkg::wavp_in_t w);
		wavp_pkg::wavp_out_t r;
		logic [7:0] b;
		int sh;
		r = '0;
		b = w.file_byte;
		if (w.restart) begin
			clear_parse();
		end
		sh = 8 * pos[1:0];
		shift_line = {b, shift_line[31:8]};
		r.byte_kind = wavp_pkg::KIND_HEADER;
		case (phase)
			P_RIFF, P_WAVE, P_FMTTAG, P_CHUNK, P_DATATAG: begin
				if (pos < 3) begin
					pos = pos + 6'd1;
				end else begin
					// tag completes on its fourth byte
					pos = '0;
					case (phase)
						P_RIFF: begin
							if (shift_line == wavp_pkg::TAG_RIFF) phase = P_RSIZE;
							else enter_error(wavp_pkg::ERR_NO_RIFF);
						end
						P_WAVE: begin
							if (shift_line == wavp_pkg::TAG_WAVE) phase = P_FMTTAG;
							else enter_error(wavp_pkg::ERR_NO_WAVE);
						end
						P_FMTTAG: begin
							if (shift_line == wavp_pkg::TAG_FMT) phase = P_FMTBODY;
							else enter_error(wavp_pkg::ERR_NO_FMT);
						end
						default: begin
							if (phase == P_CHUNK && shift_line == wavp_pkg::TAG_LIST)
								phase = P_LSIZE;
							else if (shift_line == wavp_pkg::TAG_DATA) phase = P_DSIZE;
							else enter_error(wavp_pkg::ERR_NO_DATA);
						end
					endcase
					if (phase == P_ERROR) r.byte_kind = wavp_pkg::KIND_ERROR;
				end
			end
			P_RSIZE: begin
				if (pos < 3) begin
					pos = pos + 6'd1;
				end else begin
					pos = '0;
					phase = P_WAVE;
				end
			end
			P_FMTBODY: begin
				if (pos == 6) chans = chans | {8'h00, b};
				else if (pos == 7) chans = chans | {b, 8'h00};
				else if (pos >= 8 && pos <= 11) rate = rate | ({24'h0, b} << sh);
				else if (pos == 18) bits = bits | {8'h00, b};
				else if (pos == 19) bits = bits | {b, 8'h00};
				if (pos >= 19) begin
					pos = '0;
					phase = P_CHUNK;
				end else begin
					pos = pos + 6'd1;
				end
			end
			P_LSIZE: begin
				skip_left = skip_left | ({24'h0, b} << sh);
				if (pos < 3) begin
					pos = pos + 6'd1;
				end else begin
					pos = '0;
					phase = (skip_left == 0) ? P_DATATAG : P_SKIP;
				end
			end
			P_SKIP: begin
				r.byte_kind = wavp_pkg::KIND_SKIP;
				skip_left = skip_left - 32'd1;
				if (skip_left == 0) phase = P_DATATAG;
			end
			P_DSIZE: begin
				length = length | ({24'h0, b} << sh);
				if (pos < 3) begin
					pos = pos + 6'd1;
				end else begin
					pos = '0;
					pay_left = length;
					phase = (length == 0) ? P_DONE : P_PAY;
				end
			end
			P_PAY: begin
				r.byte_kind = wavp_pkg::KIND_PAYLOAD;
				r.payload_byte = b;
				pay_left = pay_left - 32'd1;
				if (pay_left == 0) begin
					r.payload_last = 1'b1;
					phase = P_DONE;
				end
			end
			P_DONE: r.byte_kind = wavp_pkg::KIND_EXTRA;
			default: r.byte_kind = wavp_pkg::KIND_ERROR;
		endcase
		r.error_code = err;
		r.header_valid = (phase == P_PAY || phase == P_DONE);
		r.channel_count = chans;
		r.sample_rate = rate;
		r.sample_bits = bits;
		r.data_length = length;
		return r;
	endfunction

	// mostly back to back, some short pauses, a few long ones, now and then a calm stretch
	function automatic int pick_pause(inout int calm);
		int r;
		if (calm != 0) begin
			calm = calm - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 120);
			return 0;
		end
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic push_byte(logic [7:0] b, logic rs);
		wavp_pkg::wavp_in_t w;
		w.file_byte = b;
		w.restart = rs;
		file_bytes.push_back(w);
	endtask

	// little-endian, restart only on the first byte
	task automatic push_word(logic [31:0] v, logic rs);
		for (int i = 0; i < 4; i++) begin
			push_byte(v[8*i +: 8], rs && i == 0);
		end
	endtask

	task automatic push_noise(int n, bit with_restarts);
		for (int i = 0; i < n; i++) begin
			push_byte(8'($urandom_range(0, 255)),
				with_restarts && $urandom_range(0, 9) == 0);
		end
	endtask

	function automatic logic [31:0] flip(bit on);
		return on ? (32'h1 << $urandom_range(0, 31)) : 32'h0;
	endfunction

	// One file: tags, fmt section, optional LIST, data chunk. Long bodies are cut short,
	// the next file's restart ends them.
	task automatic add_file(logic [2:0] bad_tag, bit with_list, bit twin_list,
			logic [31:0] list_size, logic [31:0] data_size, int extra);
		int fill;
		int n;
		files_built++;
		fill = $urandom_range(0, 5);
		push_word(wavp_pkg::TAG_RIFF ^ flip(bad_tag == wavp_pkg::ERR_NO_RIFF), 1'b1);
		if (bad_tag == wavp_pkg::ERR_NO_RIFF) begin
			push_noise($urandom_range(1, 6), 1'b0);
			return;
		end
		push_word($urandom, 1'b0);
		push_word(wavp_pkg::TAG_WAVE ^ flip(bad_tag == wavp_pkg::ERR_NO_WAVE), 1'b0);
		if (bad_tag == wavp_pkg::ERR_NO_WAVE) begin
			push_noise($urandom_range(1, 6), 1'b0);
			return;
		end
		push_word(wavp_pkg::TAG_FMT ^ flip(bad_tag == wavp_pkg::ERR_NO_FMT), 1'b0);
		if (bad_tag == wavp_pkg::ERR_NO_FMT) begin
			push_noise($urandom_range(1, 6), 1'b0);
			return;
		end
		for (int i = 0; i < 20; i++) begin
			if (fill == 0) push_byte(8'h00, 1'b0);
			else if (fill == 1) push_byte(8'hff, 1'b0);
			else push_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		if (with_list) begin
			push_word(wavp_pkg::TAG_LIST, 1'b0);
			push_word(list_size, 1'b0);
			n = (list_size > 40) ? 40 : int'(list_size);
			push_noise(n, 1'b0);
			if (list_size > 40) return;
		end
		if (twin_list) begin
			push_word(wavp_pkg::TAG_LIST, 1'b0);
			push_noise($urandom_range(1, 6), 1'b0);
			return;
		end
		push_word(wavp_pkg::TAG_DATA ^ flip(bad_tag == wavp_pkg::ERR_NO_DATA), 1'b0);
		if (bad_tag == wavp_pkg::ERR_NO_DATA) begin
			push_noise($urandom_range(1, 6), 1'b0);
			return;
		end
		push_word(data_size, 1'b0);
		n = (data_size > 48) ? 48 : int'(data_size);
		push_noise(n, 1'b0);
		if (data_size <= 48) push_noise(extra, 1'b0);
	endtask

	// sender: offer the next byte, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_valid <= 1'b0;
			file_word <= '0;
			send_gap <= 0;
		end else begin
			if (file_valid && !file_stall) begin
				predicted_words.push_back(parse_byte(file_word));
				bytes_sent++;
			end
			if (file_valid && file_stall) begin
				input_stalls++;
			end else if (send_gap != 0) begin
				file_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (file_bytes.size() != 0) begin
				file_word <= file_bytes.pop_front();
				file_valid <= 1'b1;
				send_gap <= pick_pause(send_calm);
			end else begin
				file_valid <= 1'b0;
			end
		end
	end

	// one long hold-off on the result side while bytes keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			choke_left <= 0;
			choke_done <= 1'b0;
		end else if (!choke_done && bytes_sent >= 250) begin
			choke_left <= 300;
			choke_done <= 1'b1;
		end else if (choke_left != 0) begin
			choke_left <= choke_left - 1;
		end
	end

	// receiver: check each accepted word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : receiver
		wavp_pkg::wavp_out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (predicted_words.size() == 0) begin
					$error("result word with no byte outstanding");
					mismatches++;
				end else begin
					want = predicted_words.pop_front();
					check_field("byte_kind", 32'(want.byte_kind),
						32'(result_word.byte_kind));
					check_field("error_code", 32'(want.error_code),
						32'(result_word.error_code));
					check_field("payload_byte", 32'(want.payload_byte),
						32'(result_word.payload_byte));
					check_field("payload_last", 32'(want.payload_last),
						32'(result_word.payload_last));
					check_field("header_valid", 32'(want.header_valid),
						32'(result_word.header_valid));
					check_field("channel_count", 32'(want.channel_count),
						32'(result_word.channel_count));
					check_field("sample_rate", want.sample_rate, result_word.sample_rate);
					check_field("sample_bits", 32'(want.sample_bits),
						32'(result_word.sample_bits));
					check_field("data_length", want.data_length, result_word.data_length);
				end
				if (result_word.byte_kind <= wavp_pkg::KIND_EXTRA)
					kind_count[result_word.byte_kind]++;
			end
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				result_stall <= (choke_left != 0);
				stall_left <= pick_pause(recv_calm);
			end
		end
	end

	initial begin : stimulus
		int k;
		int r;
		logic [2:0] bad;
		logic [31:0] lsize;
		logic [31:0] dsize;
		clear_parse();
		foreach (kind_count[i]) kind_count[i] = 0;

		// bad RIFF tag ending in all ones, then a byte while in error
		push_byte("R", 1'b1);
		push_byte("I", 1'b0);
		push_byte("F", 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b0);
		// good RIFF and WAVE, all-ones size, near-miss fmt tag
		push_word(wavp_pkg::TAG_RIFF, 1'b1);
		push_word(32'hffff_ffff, 1'b0);
		push_word(wavp_pkg::TAG_WAVE, 1'b0);
		push_word(wavp_pkg::TAG_FMT ^ 32'h8000_0000, 1'b0);
		push_byte(8'h80, 1'b0);
		// restart on a lone byte in the middle of a stream
		push_byte(8'h52, 1'b1);

		k = 0;
		while (file_bytes.size() < 820) begin
			case (k)
				0: add_file(wavp_pkg::ERR_NONE, 1'b1, 1'b0, 32'd0, 32'd0, 3);
				1: add_file(wavp_pkg::ERR_NONE, 1'b1, 1'b1, 32'd3, 32'd0, 0);
				2: add_file(wavp_pkg::ERR_NONE, 1'b0, 1'b0, 32'd0, 32'hffff_ffff, 0);
				3: add_file(wavp_pkg::ERR_NONE, 1'b1, 1'b0, 32'hffff_ffff, 32'd0, 0);
				4: add_file(wavp_pkg::ERR_NONE, 1'b1, 1'b0, 32'd5, 32'd1, 2);
				default: begin
					r = $urandom_range(0, 15);
					if (r == 0) bad = wavp_pkg::ERR_NO_RIFF;
					else if (r == 1) bad = wavp_pkg::ERR_NO_WAVE;
					else if (r == 2) bad = wavp_pkg::ERR_NO_FMT;
					else if (r == 3) bad = wavp_pkg::ERR_NO_DATA;
					else bad = wavp_pkg::ERR_NONE;
					lsize = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12);
					dsize = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 30);
					if ($urandom_range(0, 11) == 0) begin
						push_noise($urandom_range(1, 10), 1'b1);
					end else begin
						add_file(bad, 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0,
							lsize, dsize, $urandom_range(0, 3));
					end
				end
			endcase
			k++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (file_bytes.size() != 0 || file_valid || predicted_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		$display("covered %0d bytes in %0d files: payload %0d, skipped %0d, error %0d, extra %0d",
			bytes_sent, files_built, kind_count[wavp_pkg::KIND_PAYLOAD],
			kind_count[wavp_pkg::KIND_SKIP], kind_count[wavp_pkg::KIND_ERROR],
			kind_count[wavp_pkg::KIND_EXTRA]);
		$display("input held back on %0d cycles", input_stalls);
		if (mismatches == 0) begin
			$display("wav_header_parser_unit_test: clean");
		end else begin
			$display("wav_header_parser_unit_test: errors");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("wav_header_parser_unit_test: errors");
		$finish;
	end

endmodule
